// ===== hdl/fnv1_hash_collision_checker_defines.svh =====
// ----------------------------------------------------------------------------
// FNV-1 hash collision checker: assertion macros
// Shared property macros for the checker RTL; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FNV1_HASH_COLLISION_CHECKER_DEFINES_SVH
`define FNV1_HASH_COLLISION_CHECKER_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication.
`define FHC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fhc assertion failed");
// Next-cycle implication.
`define FHC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fhc assertion failed");
`else
`define FHC_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define FHC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/fhc_pkg.sv =====
// ----------------------------------------------------------------------------
// FNV-1 hash collision checker: package
// Field widths, function and register codes, reset values and shared types.
// ----------------------------------------------------------------------------
package fhc_pkg;

   localparam int HASH_W    = 64;
   localparam int HALF_W    = 32;
   localparam int BYTE_W    = 8;
   localparam int FUNC_W    = 2;
   localparam int IDENT_W   = 7;
   localparam int WMODE_W   = 2;
   localparam int CSR_IDX_W = 2;

   localparam int DEFAULT_TABLE_DEPTH = 64;

   // Selectable hash widths
   localparam int HASH_BITS_8  = 8;
   localparam int HASH_BITS_16 = 16;
   localparam int HASH_BITS_32 = 32;
   localparam int HASH_BITS_64 = 64;

   localparam logic [WMODE_W-1:0] WMODE_8  = 2'd0;
   localparam logic [WMODE_W-1:0] WMODE_16 = 2'd1;
   localparam logic [WMODE_W-1:0] WMODE_32 = 2'd2;
   localparam logic [WMODE_W-1:0] WMODE_64 = 2'd3;

   localparam logic [FUNC_W-1:0] FUNC_ADD_BYTE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_END      = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH_MODE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_BASIS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HASH_PRIME   = 2'd2;

   localparam logic [WMODE_W-1:0] RESET_WIDTH_MODE   = WMODE_64;
   localparam logic [HASH_W-1:0]  RESET_OFFSET_BASIS = 64'hcbf2_9ce4_8422_2325;
   localparam logic [HASH_W-1:0]  RESET_HASH_PRIME   = 64'h0000_0100_0000_01b3;

   // Probe token handed from cell to cell along the table
   typedef struct packed {
      logic valid;
      logic match;
   } fhc_token_type;

   function automatic logic [HASH_W-1:0] width_mask(input logic [WMODE_W-1:0] mode);
      logic [HASH_W-1:0] ones;
      logic [HASH_W-1:0] mask;
      ones = {HASH_W{1'b1}};
      unique case (mode)
         WMODE_8:  mask = ones >> (HASH_W - HASH_BITS_8);
         WMODE_16: mask = ones >> (HASH_W - HASH_BITS_16);
         WMODE_32: mask = ones >> (HASH_W - HASH_BITS_32);
         default:  mask = ones >> (HASH_W - HASH_BITS_64);
      endcase
      return mask;
   endfunction

endpackage

// ===== hdl/fhc_if.sv =====
// ----------------------------------------------------------------------------
// FNV-1 hash collision checker: channel interfaces
// Valid/ready channels for requests, responses and register writes.
// ----------------------------------------------------------------------------
interface fhc_req_if;
   logic                       valid;
   logic                       ready;
   logic [fhc_pkg::FUNC_W-1:0] func;
   logic [fhc_pkg::BYTE_W-1:0] char_byte;

   modport source (output valid, output func, output char_byte, input ready);
   modport sink   (input valid, input func, input char_byte, output ready);
endinterface

interface fhc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [fhc_pkg::HASH_W-1:0]  hash_value;
   logic [fhc_pkg::IDENT_W-1:0] ident_index;
   logic                        is_duplicate;
   logic                        table_full;

   modport source (output valid, output hash_value, output ident_index,
                   output is_duplicate, output table_full, input ready);
   modport sink   (input valid, input hash_value, input ident_index,
                   input is_duplicate, input table_full, output ready);
endinterface

interface fhc_csr_if;
   logic                          valid;
   logic                          ready;
   logic [fhc_pkg::CSR_IDX_W-1:0] index;
   logic [fhc_pkg::HASH_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/fnv1_hash_collision_checker.sv =====
// ----------------------------------------------------------------------------
// FNV-1 hash collision checker
// Hashes identifiers byte by byte and flags repeated hashes in a stored set.
// ----------------------------------------------------------------------------
// One request is worked at a time. For an add-byte request the 64-bit
// multiply by the prime runs as four steps of one shared 32x32 multiplier.
// For an end request a probe token walks the row of TABLE_DEPTH table
// cells, one cell per cycle, collecting the duplicate flag. A clear or an
// unused code completes in the idle state. Register writes are taken in any
// cycle and must only be issued while no request is in flight. The response
// sits in its own output register, so a pending response does not block new
// bytes.
// ----------------------------------------------------------------------------
module fnv1_hash_collision_checker #(
   parameter int TABLE_DEPTH = fhc_pkg::DEFAULT_TABLE_DEPTH
) (
   input logic        clock,
   input logic        reset,
   fhc_req_if.sink    req_if,
   fhc_rsp_if.source  rsp_if,
   fhc_csr_if.sink    csr_if
);
   import fhc_pkg::*;

`include "fnv1_hash_collision_checker_defines.svh"

   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W = $clog2(TABLE_DEPTH);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_MUL    = 2'd1;
   localparam logic [1:0] ST_PROBE  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [WMODE_W-1:0] wmode_ff, wmode_in;
   logic [HASH_W-1:0]  basis_ff, basis_in;
   logic [HASH_W-1:0]  prime_ff, prime_in;
   logic [HASH_W-1:0]  running_ff, running_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [BYTE_W-1:0]  byte_ff, byte_in;
   logic               dup_ff, dup_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [HASH_W-1:0]  rsp_hash_ff, rsp_hash_in;
   logic [IDENT_W-1:0] rsp_ident_ff, rsp_ident_in;
   logic               rsp_dup_ff, rsp_dup_in;
   logic               rsp_full_ff, rsp_full_in;

   logic               req_accept;
   logic               csr_accept;
   logic [HASH_W-1:0]  mask;
   logic               mul_start;
   logic               mul_done;
   logic [HASH_W-1:0]  mul_result;
   logic               wr_en;
   logic               table_is_full;
   logic               slot_free;

   fhc_token_type      tok [TABLE_DEPTH + 1];

   assign req_if.ready = (state_ff == ST_IDLE);
   assign csr_if.ready = 1'b1;
   assign req_accept   = req_if.valid && req_if.ready;
   assign csr_accept   = csr_if.valid && csr_if.ready;
   assign mask         = width_mask(wmode_ff);

   assign table_is_full = (count_ff == CNT_W'(TABLE_DEPTH));
   assign slot_free     = !rsp_valid_ff || rsp_if.ready;
   assign mul_start     = req_accept && (req_if.func == FUNC_ADD_BYTE);
   assign wr_en         = (state_ff == ST_FINISH) && slot_free && !table_is_full;

   // inject a fresh probe token at the head of the row
   assign tok[0].valid = req_accept && (req_if.func == FUNC_END);
   assign tok[0].match = 1'b0;

   fhc_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .op_a   (running_ff),
      .op_b   (prime_ff & mask),
      .done   (mul_done),
      .result (mul_result)
   );

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      fhc_cell #(
         .DEPTH (TABLE_DEPTH),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .tok_in     (tok[i]),
         .tok_out    (tok[i+1]),
         .probe_hash (running_ff),
         .count      (count_ff),
         .wr_en      (wr_en),
         .wr_addr    (ADDR_W'(count_ff)),
         .wr_data    (running_ff)
      );
   end

   always_comb begin
      state_in     = state_ff;
      wmode_in     = wmode_ff;
      basis_in     = basis_ff;
      prime_in     = prime_ff;
      running_in   = running_ff;
      count_in     = count_ff;
      byte_in      = byte_ff;
      dup_in       = dup_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_hash_in  = rsp_hash_ff;
      rsp_ident_in = rsp_ident_ff;
      rsp_dup_in   = rsp_dup_ff;
      rsp_full_in  = rsp_full_ff;

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_if.func)
                  FUNC_ADD_BYTE: begin
                     byte_in  = req_if.char_byte;
                     state_in = ST_MUL;
                  end
                  FUNC_END:   state_in = ST_PROBE;
                  FUNC_CLEAR: count_in = '0;
                  default:    ;
               endcase
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               running_in = (mul_result & mask) ^ HASH_W'(byte_ff);
               state_in   = ST_IDLE;
            end
         end
         ST_PROBE: begin
            if (tok[TABLE_DEPTH].valid) begin
               dup_in   = tok[TABLE_DEPTH].match;
               state_in = ST_FINISH;
            end
         end
         default: begin
            // hold until the output register is free
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = running_ff;
               rsp_ident_in = IDENT_W'(count_ff);
               rsp_dup_in   = dup_ff;
               rsp_full_in  = table_is_full;
               if (!table_is_full) begin
                  count_in = count_ff + CNT_W'(1);
               end
               running_in = basis_ff & mask;
               state_in   = ST_IDLE;
            end
         end
      endcase

      if (csr_accept) begin
         unique case (csr_if.index)
            CSR_WIDTH_MODE: begin
               wmode_in   = csr_if.data[WMODE_W-1:0];
               running_in = basis_ff & width_mask(csr_if.data[WMODE_W-1:0]);
            end
            CSR_OFFSET_BASIS: begin
               basis_in   = csr_if.data;
               running_in = csr_if.data & mask;
            end
            CSR_HASH_PRIME: prime_in = csr_if.data;
            default:        ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wmode_ff     <= RESET_WIDTH_MODE;
         basis_ff     <= RESET_OFFSET_BASIS;
         prime_ff     <= RESET_HASH_PRIME;
         running_ff   <= RESET_OFFSET_BASIS & width_mask(RESET_WIDTH_MODE);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wmode_ff     <= wmode_in;
         basis_ff     <= basis_in;
         prime_ff     <= prime_in;
         running_ff   <= running_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      dup_ff       <= dup_in;
      rsp_hash_ff  <= rsp_hash_in;
      rsp_ident_ff <= rsp_ident_in;
      rsp_dup_ff   <= rsp_dup_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.hash_value   = rsp_hash_ff;
   assign rsp_if.ident_index  = rsp_ident_ff;
   assign rsp_if.is_duplicate = rsp_dup_ff;
   assign rsp_if.table_full   = rsp_full_ff;

   `FHC_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(TABLE_DEPTH))
   `FHC_ASSERT_IMPL(a_token_in_probe, clock, reset, tok[TABLE_DEPTH].valid, state_ff == ST_PROBE)
   `FHC_ASSERT_NEXT(a_byte_starts_mul, clock, reset, mul_start, state_ff == ST_MUL)
   `FHC_ASSERT_IMPL(a_full_index, clock, reset, rsp_valid_ff && rsp_full_ff, rsp_ident_ff == IDENT_W'(TABLE_DEPTH))

endmodule

// ===== hdl/fhc_mul.sv =====
// ----------------------------------------------------------------------------
// FNV-1 hash collision checker: truncating multiplier
// Low 64 bits of a 64x64 product from one shared 32x32 multiplier, 4 steps.
// ----------------------------------------------------------------------------
module fhc_mul (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [fhc_pkg::HASH_W-1:0] op_a,
   input  logic [fhc_pkg::HASH_W-1:0] op_b,
   output logic                       done,
   output logic [fhc_pkg::HASH_W-1:0] result
);
   import fhc_pkg::*;

   localparam logic [1:0] STEP_LL   = 2'd0;
   localparam logic [1:0] STEP_LH   = 2'd1;
   localparam logic [1:0] STEP_HL   = 2'd2;
   localparam logic [1:0] STEP_SUM  = 2'd3;

   logic                busy_ff, busy_in;
   logic [1:0]          step_ff, step_in;
   logic                done_ff, done_in;
   logic [HASH_W-1:0]   a_ff, a_in;
   logic [HASH_W-1:0]   b_ff, b_in;
   logic [HASH_W-1:0]   prod_ff, prod_in;
   logic [HASH_W-1:0]   lo_ff, lo_in;
   logic [HALF_W-1:0]   cross_ff, cross_in;
   logic [HASH_W-1:0]   result_ff, result_in;
   logic [HALF_W-1:0]   mul_x, mul_y;

   always_comb begin
      unique case (step_ff)
         STEP_LL:  begin mul_x = a_ff[HALF_W-1:0];      mul_y = b_ff[HALF_W-1:0];      end
         STEP_LH:  begin mul_x = a_ff[HALF_W-1:0];      mul_y = b_ff[HASH_W-1:HALF_W]; end
         STEP_HL:  begin mul_x = a_ff[HASH_W-1:HALF_W]; mul_y = b_ff[HALF_W-1:0];      end
         default:  begin mul_x = a_ff[HALF_W-1:0];      mul_y = b_ff[HALF_W-1:0];      end
      endcase
   end

   always_comb begin
      busy_in   = busy_ff;
      step_in   = step_ff;
      done_in   = 1'b0;
      a_in      = a_ff;
      b_in      = b_ff;
      prod_in   = prod_ff;
      lo_in     = lo_ff;
      cross_in  = cross_ff;
      result_in = result_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_LL;
         a_in    = op_a;
         b_in    = op_b;
      end else if (busy_ff) begin
         prod_in = HASH_W'(mul_x) * HASH_W'(mul_y);
         step_in = step_ff + 2'd1;
         unique case (step_ff)
            STEP_LL:  ;
            STEP_LH:  lo_in = prod_ff;
            STEP_HL:  cross_in = prod_ff[HALF_W-1:0];
            STEP_SUM: begin
               // cross terms only reach the upper half
               result_in = {lo_ff[HASH_W-1:HALF_W] + cross_ff + prod_ff[HALF_W-1:0],
                            lo_ff[HALF_W-1:0]};
               done_in   = 1'b1;
               busy_in   = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_LL;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      b_ff      <= b_in;
      prod_ff   <= prod_in;
      lo_ff     <= lo_in;
      cross_ff  <= cross_in;
      result_ff <= result_in;
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

// ===== hdl/fhc_cell.sv =====
// ----------------------------------------------------------------------------
// FNV-1 hash collision checker: table cell
// Holds one stored hash and folds its compare into the passing probe token.
// ----------------------------------------------------------------------------
module fhc_cell #(
   parameter  int DEPTH  = fhc_pkg::DEFAULT_TABLE_DEPTH,
   parameter  int INDEX  = 0,
   localparam int CNT_W  = $clog2(DEPTH + 1),
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  fhc_pkg::fhc_token_type     tok_in,
   output fhc_pkg::fhc_token_type     tok_out,
   input  logic [fhc_pkg::HASH_W-1:0] probe_hash,
   input  logic [CNT_W-1:0]           count,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic [fhc_pkg::HASH_W-1:0] wr_data
);
   import fhc_pkg::*;

   logic [HASH_W-1:0] entry_ff, entry_in;
   fhc_token_type     tok_ff, tok_in_nxt;
   logic              occupied;

   // only entries below the fill count take part
   assign occupied = count > CNT_W'(INDEX);

   always_comb begin
      entry_in = entry_ff;
      if (wr_en && (wr_addr == ADDR_W'(INDEX))) begin
         entry_in = wr_data;
      end
   end

   always_comb begin
      tok_in_nxt.valid = tok_in.valid;
      tok_in_nxt.match = tok_in.match | (tok_in.valid & occupied & (entry_ff == probe_hash));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_nxt;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign tok_out = tok_ff;

endmodule
